[rtl/mwts_pkg.sv]
// ----------------------------------------------------------------------------
// mwts_pkg
// Shared constants, types and the quarter-wave sine table of the tone synth.
// ----------------------------------------------------------------------------
package mwts_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int TBL_N           = 1 << TABLE_ADDR_BITS;
  localparam int ROM_ADDR_W      = TABLE_ADDR_BITS + 1;
  localparam int TURN_W          = 32;
  localparam int SAMPLE_W        = 32;
  localparam int PEAK_W          = 31;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_SAW,
    WAVE_SQUARE,
    WAVE_TRIANGLE
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP,
    CFG_WAVE_KIND,
    CFG_SAMPLE_SIZE,
    CFG_TOTAL_SAMPLES
  } cfg_idx_e;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  typedef struct packed {
    logic [TURN_W-1:0] turn;
    logic              last;
    wave_e             kind;
    logic [1:0]        size;
  } mwts_item_t;

  typedef logic [PEAK_W-1:0] sine_rom_t [TBL_N+1];

  function automatic logic [PEAK_W-1:0] peak_of(logic [1:0] size);
    logic [PEAK_W-1:0] peak;
    unique case (size)
      SIZE_8:  peak = PEAK_W'(127);
      SIZE_16: peak = PEAK_W'(32767);
      default: peak = {PEAK_W{1'b1}};
    endcase
    return peak;
  endfunction

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] horner_div(int j, logic [63:0] p);
    logic [63:0] q;
    unique case (j)
      0:       q = p / 64'd210;
      1:       q = p / 64'd156;
      2:       q = p / 64'd110;
      3:       q = p / 64'd72;
      4:       q = p / 64'd42;
      5:       q = p / 64'd20;
      default: q = p / 64'd6;
    endcase
    return q;
  endfunction

  function automatic logic [PEAK_W-1:0] sine_q31(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x2 = mul_q62(x, x);
    t  = ONE_Q62;
    for (int j = 0; j < 7; j++) begin
      t = ONE_Q62 - horner_div(j, mul_q62(x2, t));
    end
    s = mul_q62(x, t);
    r = (s + 64'h4000_0000) >> 31;
    return (r > 64'h7FFF_FFFF) ? {PEAK_W{1'b1}} : r[PEAK_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] unit;
    unit = HALF_PI_Q62 >> TABLE_ADDR_BITS;
    for (int k = 0; k <= TBL_N; k++) begin
      rom[k] = sine_q31(unit * 64'(k));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[rtl/mwts_front.sv]
// ----------------------------------------------------------------------------
// mwts_front
// Configuration registers, phase accumulator and sample counter; classifies
// ticks and queues the ones that yield a sample.
// ----------------------------------------------------------------------------
module mwts_front import mwts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  advance_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output mwts_item_t            q_item_o
);

  localparam int ShDown = (PHASE_BITS > TURN_W) ? PHASE_BITS - TURN_W : 0;
  localparam int ShUp   = (PHASE_BITS < TURN_W) ? TURN_W - PHASE_BITS : 0;

  logic [31:0]           step_q;
  wave_e                 kind_q;
  logic [1:0]            size_q;
  logic [31:0]           total_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [31:0]           done_q, done_d;
  logic                  accept;
  logic                  run;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign run        = advance_i && (done_q < total_q);
  assign q_push_o   = accept && run;

  assign phase_d = phase_q + PHASE_BITS'(step_q);
  assign done_d  = done_q + 32'd1;

  always_comb begin
    q_item_o.turn = TURN_W'((64'(phase_d) >> ShDown) << ShUp);
    q_item_o.last = (done_d == total_q);
    q_item_o.kind = kind_q;
    q_item_o.size = size_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      kind_q  <= WAVE_SINE;
      size_q  <= SIZE_16;
      total_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PHASE_STEP:    step_q  <= cfg_wdata_i;
        CFG_WAVE_KIND:     kind_q  <= wave_e'(cfg_wdata_i[1:0]);
        CFG_SAMPLE_SIZE:   size_q  <= cfg_wdata_i[1:0];
        CFG_TOTAL_SAMPLES: total_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      done_q  <= '0;
    end else if (q_push_o) begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

endmodule

[rtl/mwts_queue.sv]
// ----------------------------------------------------------------------------
// mwts_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module mwts_queue import mwts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mwts_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output mwts_item_t item_o
);

  mwts_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      priority if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end else begin
        count_q <= count_q;
      end
    end
  end

endmodule

[rtl/mwts_back.sv]
// ----------------------------------------------------------------------------
// mwts_back
// Waveform datapath: sine table read, peak scaling, sign and output register.
// ----------------------------------------------------------------------------
module mwts_back import mwts_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  mwts_item_t                 q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_value_o,
  output logic                       last_sample_o
);

  logic                        adv;
  logic [1:0]                  quad;
  logic [TABLE_ADDR_BITS-1:0]  idx;
  logic [ROM_ADDR_W-1:0]       rom_addr;
  logic [TURN_W:0]             saw_d;
  logic [TURN_W:0]             tri_w;
  logic [TURN_W:0]             tri_m;
  logic                        tri_neg;
  logic [31:0]                 alt_op;
  logic                        alt_neg;

  logic [PEAK_W-1:0]           rom_q;
  logic                        s1_valid_q;
  logic [31:0]                 s1_op_q;
  logic                        s1_neg_q;
  wave_e                       s1_kind_q;
  logic [1:0]                  s1_size_q;
  logic                        s1_last_q;
  logic [31:0]                 mul_op;

  logic                        s2_valid_q;
  logic [PEAK_W+31:0]          prod_q;
  logic                        s2_neg_q;
  wave_e                       s2_kind_q;
  logic [1:0]                  s2_size_q;
  logic                        s2_last_q;
  logic [31:0]                 mag;
  logic [31:0]                 peak32;
  logic [SAMPLE_W-1:0]         res;

  logic                        out_valid_q;
  logic [SAMPLE_W-1:0]         sample_q;
  logic                        last_q;

  // advance the whole pipe whenever the output register frees up
  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && !q_empty_i;

  always_comb begin
    quad     = q_item_i.turn[TURN_W-1 -: 2];
    idx      = q_item_i.turn[TURN_W-3 -: TABLE_ADDR_BITS];
    rom_addr = quad[0] ? ROM_ADDR_W'(TBL_N) - {1'b0, idx} : {1'b0, idx};

    saw_d = q_item_i.turn[TURN_W-1] ? (33'h1_0000_0000 - {1'b0, q_item_i.turn})
                                    : {1'b0, q_item_i.turn};

    priority if (q_item_i.turn < 32'h4000_0000) begin
      tri_w = {1'b0, q_item_i.turn} + 33'h0_4000_0000;
    end else if (q_item_i.turn < 32'hC000_0000) begin
      tri_w = 33'h0_C000_0000 - {1'b0, q_item_i.turn};
    end else begin
      tri_w = {1'b0, q_item_i.turn} - 33'h0_C000_0000;
    end
    tri_neg = tri_w < 33'h0_4000_0000;
    tri_m   = tri_neg ? (33'h0_4000_0000 - tri_w) : (tri_w - 33'h0_4000_0000);

    unique case (q_item_i.kind)
      WAVE_SAW: begin
        alt_op  = saw_d[31:0];
        alt_neg = q_item_i.turn[TURN_W-1];
      end
      WAVE_TRIANGLE: begin
        alt_op  = {tri_m[30:0], 1'b0};
        alt_neg = tri_neg;
      end
      default: begin
        alt_op  = '0;
        alt_neg = quad[1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rom_q     <= SINE_ROM[rom_addr];
      s1_op_q   <= alt_op;
      s1_neg_q  <= alt_neg;
      s1_kind_q <= q_item_i.kind;
      s1_size_q <= q_item_i.size;
      s1_last_q <= q_item_i.last;
    end
  end

  assign mul_op = (s1_kind_q == WAVE_SINE || s1_kind_q == WAVE_SQUARE) ?
                  {1'b0, rom_q} : s1_op_q;

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      prod_q    <= {32'd0, peak_of(s1_size_q)} * {{PEAK_W{1'b0}}, mul_op};
      s2_neg_q  <= s1_neg_q;
      s2_kind_q <= s1_kind_q;
      s2_size_q <= s1_size_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    mag    = prod_q[PEAK_W+31 -: 32];
    peak32 = {1'b0, peak_of(s2_size_q)};
    if (s2_kind_q == WAVE_SQUARE) begin
      res = (s2_neg_q && mag != '0) ? (32'd0 - peak32) : peak32;
    end else begin
      res = s2_neg_q ? (32'd0 - mag) : mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      sample_q <= res;
      last_q   <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_empty_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;
  assign last_sample_o  = last_q;

endmodule

[rtl/multi_waveform_tone_synth.sv]
// ----------------------------------------------------------------------------
// multi_waveform_tone_synth
// Phase-accumulator tone generator with sine, sawtooth, square and triangle.
// ----------------------------------------------------------------------------
// The block takes one tick item per clock cycle while the queue has room.
// A tick with advance set, while fewer than total_samples samples have been
// made, steps the phase and yields one sample; other ticks are taken
// and dropped. The rate is set by the phase accumulator, a single add in the
// front; the back is a three-stage pipe (registered sine table read, peak
// multiply, sign and output register) fed through a four-entry item queue,
// so a stalled output holds the back while the front keeps taking ticks
// until the queue fills. Write configuration only while no sample is pending.
module multi_waveform_tone_synth import mwts_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       advance_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_value_o,
  output logic                       last_sample_o
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  mwts_item_t q_wr_item;
  mwts_item_t q_rd_item;

  mwts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .advance_i   (advance_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_wr_item)
  );

  mwts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_rd_item)
  );

  mwts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (q_rd_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o),
    .last_sample_o  (last_sample_o)
  );

endmodule
